// File: rtl/core/ses_pkg.sv
// ----------------------------------------------------------------------------
// ses_pkg
// Shared types and constants for the sprite evaluation scan unit.
// ----------------------------------------------------------------------------
package ses_pkg;

    localparam int PRIMARY_BYTES    = 256;
    localparam int SECONDARY_BYTES  = 32;
    localparam int SPRITES_PER_LINE = 8;
    localparam int PRI_AW           = $clog2(PRIMARY_BYTES);
    localparam int SEC_AW           = $clog2(SECONDARY_BYTES);
    localparam int OUTQ_DEPTH       = 3;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_TABLE_WRITE = 2'd0,
        OP_LINE_START  = 2'd1,
        OP_EVAL_DOT    = 2'd2,
        OP_SEC_READ    = 2'd3
    } t_op;

    // Where the latched byte comes from in the cycle after a request
    typedef enum logic [1:0] {
        LAT_REG = 2'd0,
        LAT_PRI = 2'd1,
        LAT_SEC = 2'd2
    } t_lat_src;

    // One result request
    typedef struct packed {
        logic [7:0] bus_value;
        logic       overflow;
        logic       zero_in_range;
        logic       zero_for_line;
        logic [6:0] sprites_found;
    } t_result;

    // RAM write/read port request
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [7:0] raddr;
    } t_ram_req;

endpackage

// File: rtl/core/sprite_evaluation_scan_unit.sv
// ----------------------------------------------------------------------------
// sprite_evaluation_scan_unit
// Per-dot sprite evaluation with primary and secondary object tables.
// ----------------------------------------------------------------------------
// One request is accepted every cycle while s_axis_tready is high; its result
// passes through the registered read of the primary or secondary table RAM and
// then through the result queue. The latched byte is forwarded from the RAM
// read port to the next request, so dot-by-dot streams run at full rate.
// Input ready drops only when the result stage and the three-entry result
// queue together hold three results because the output side is stalled.
module sprite_evaluation_scan_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,    // tall_sprites
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] table_address, [15:8] table_data, [23:16] line_y,
    // [31:24] scan_start, [32] rendering_on, [33] clear_flags
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,     // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] bus_value, [8] overflow, [9] zero_in_range, [10] zero_for_line,
    // [17:11] sprites_found
    output logic [23:0] m_axis_tdata
);

    logic r_tall;
    logic fire, s1_valid, push;
    logic [1:0] q_count;
    logic [7:0] pri_rdata, sec_rdata;
    ses_pkg::t_ram_req pri_req, sec_req;
    ses_pkg::t_result  result, q_data;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tall <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_tall <= i_cfg_wr_data;
        end
    end

    // Room check covers the result stage plus the queue
    assign s_axis_tready = ({1'b0, q_count} + {2'd0, s1_valid}) < 3'(ses_pkg::OUTQ_DEPTH);
    assign fire          = s_axis_tvalid && s_axis_tready;

    ses_eval u_eval (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_op            (ses_pkg::t_op'(s_axis_tuser)),
        .i_table_address (s_axis_tdata[7:0]),
        .i_table_data    (s_axis_tdata[15:8]),
        .i_line_y        (s_axis_tdata[23:16]),
        .i_scan_start    (s_axis_tdata[31:24]),
        .i_rendering_on  (s_axis_tdata[32]),
        .i_clear_flags   (s_axis_tdata[33]),
        .i_tall          (r_tall),
        .i_pri_rdata     (pri_rdata),
        .i_sec_rdata     (sec_rdata),
        .o_pri_req       (pri_req),
        .o_sec_req       (sec_req),
        .o_s1_valid      (s1_valid),
        .o_push          (push),
        .o_result        (result)
    );

    ses_ram #(
        .WIDTH (8),
        .DEPTH (ses_pkg::PRIMARY_BYTES)
    ) u_pri_ram (
        .i_clk   (i_clk),
        .i_we    (pri_req.we),
        .i_waddr (pri_req.waddr[ses_pkg::PRI_AW-1:0]),
        .i_wdata (pri_req.wdata),
        .i_raddr (pri_req.raddr[ses_pkg::PRI_AW-1:0]),
        .o_rdata (pri_rdata)
    );

    ses_ram #(
        .WIDTH (8),
        .DEPTH (ses_pkg::SECONDARY_BYTES)
    ) u_sec_ram (
        .i_clk   (i_clk),
        .i_we    (sec_req.we),
        .i_waddr (sec_req.waddr[ses_pkg::SEC_AW-1:0]),
        .i_wdata (sec_req.wdata),
        .i_raddr (sec_req.raddr[ses_pkg::SEC_AW-1:0]),
        .o_rdata (sec_rdata)
    );

    ses_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign m_axis_tdata = {6'd0, q_data.sprites_found, q_data.zero_for_line,
                           q_data.zero_in_range, q_data.overflow, q_data.bus_value};

endmodule

// File: rtl/core/ses_ram.sv
// ----------------------------------------------------------------------------
// ses_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ses_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ses_outq.sv
// ----------------------------------------------------------------------------
// ses_outq
// Small result queue that decouples the evaluator from the output stall.
// ----------------------------------------------------------------------------
module ses_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ses_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output ses_pkg::t_result o_data,
    output logic [1:0]       o_count
);

    ses_pkg::t_result r_buf [ses_pkg::OUTQ_DEPTH];
    logic [1:0] r_wptr, r_rptr, r_count;
    logic [1:0] n_wptr, n_rptr, n_count;
    logic       pop;

    assign pop     = (r_count != 2'd0) && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_buf[r_rptr];
    assign o_count = r_count;

    // Pointer and count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == 2'(ses_pkg::OUTQ_DEPTH - 1)) ? 2'd0 : r_wptr + 2'd1;
        end
        if (pop) begin
            n_rptr = (r_rptr == 2'(ses_pkg::OUTQ_DEPTH - 1)) ? 2'd0 : r_rptr + 2'd1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 2'd0;
            r_rptr  <= 2'd0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

endmodule

// File: rtl/core/ses_eval.sv
// ----------------------------------------------------------------------------
// ses_eval
// Evaluation sequencer: holds the scan state, drives both table RAMs and
// resolves the latched byte in the cycle after each request.
// ----------------------------------------------------------------------------
module ses_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  ses_pkg::t_op        i_op,
    input  logic [7:0]          i_table_address,
    input  logic [7:0]          i_table_data,
    input  logic [7:0]          i_line_y,
    input  logic [7:0]          i_scan_start,
    input  logic                i_rendering_on,
    input  logic                i_clear_flags,
    input  logic                i_tall,
    input  logic [7:0]          i_pri_rdata,
    input  logic [7:0]          i_sec_rdata,
    output ses_pkg::t_ram_req   o_pri_req,
    output ses_pkg::t_ram_req   o_sec_req,
    output logic                o_s1_valid,
    output logic                o_push,
    output ses_pkg::t_result    o_result
);

    // Scan state
    logic [6:0] r_slot, n_slot;
    logic [8:0] r_scan, n_scan;
    logic [2:0] r_bis, n_bis;
    logic [7:0] r_latched;
    logic [8:0] r_dot, n_dot;
    logic       r_copy, n_copy;
    logic       r_zf, n_zf;
    logic       r_zl, n_zl;
    logic       r_ovf, n_ovf;
    logic [7:0] r_line, n_line;
    logic [7:0] r_start, n_start;
    ses_pkg::t_lat_src r_pend, n_pend;

    // Secondary table reset image: entries read as all ones until written
    logic [ses_pkg::SECONDARY_BYTES-1:0] r_sec_vld;
    logic       r_sec_vld_rd;

    // Result stage
    logic       r_s1_valid;
    logic       r_s1_sec;
    logic       r_s1_ovf, r_s1_zf, r_s1_zl;
    logic [6:0] r_s1_slot;

    logic [7:0] sec_data, cur_lat;
    logic       hit;
    logic [8:0] y_top;
    logic [9:0] idx;
    logic [6:0] sl;
    logic [8:0] s;

    assign sec_data = r_sec_vld_rd ? i_sec_rdata : 8'hFF;

    // Latched byte as left by the previous request
    always_comb begin
        case (r_pend)
            ses_pkg::LAT_PRI: cur_lat = i_pri_rdata;
            ses_pkg::LAT_SEC: cur_lat = sec_data;
            default:          cur_lat = r_latched;
        endcase
    end

    // Sprite y range test
    assign y_top = {1'b0, cur_lat} + (i_tall ? 9'd16 : 9'd8);
    assign hit   = (r_line >= cur_lat) && ({1'b0, r_line} < y_top);

    // Next-state logic for one request
    always_comb begin
        n_slot  = r_slot;
        n_scan  = r_scan;
        n_bis   = r_bis;
        n_dot   = r_dot;
        n_copy  = r_copy;
        n_zf    = r_zf;
        n_zl    = r_zl;
        n_ovf   = r_ovf;
        n_line  = r_line;
        n_start = r_start;
        n_pend  = ses_pkg::LAT_REG;
        o_pri_req = '0;
        o_sec_req = '0;
        sl  = r_slot;
        s   = r_scan;
        idx = '0;
        if (i_fire) begin
            unique case (i_op)
                ses_pkg::OP_TABLE_WRITE: begin
                    o_pri_req.we    = 1'b1;
                    o_pri_req.waddr = i_table_address;
                    o_pri_req.wdata = i_table_data;
                end
                ses_pkg::OP_LINE_START: begin
                    n_bis   = '0;
                    n_slot  = '0;
                    n_scan  = '0;
                    n_copy  = 1'b1;
                    n_zl    = r_zf;
                    n_line  = i_line_y;
                    n_start = i_scan_start;
                    n_dot   = '0;
                    if (i_clear_flags) begin
                        n_ovf = 1'b0;
                    end
                end
                ses_pkg::OP_EVAL_DOT: begin
                    if (!r_dot[8]) begin
                        n_dot = r_dot + 9'd1;
                        if (i_rendering_on) begin
                            if (r_dot < 9'd64) begin
                                // Secondary clear phase
                                if (r_dot[0]) begin
                                    if (r_slot < 7'(ses_pkg::SECONDARY_BYTES)) begin
                                        o_sec_req.we    = 1'b1;
                                        o_sec_req.waddr = {3'd0, r_slot[4:0]};
                                        o_sec_req.wdata = 8'hFF;
                                    end
                                    n_slot = r_slot + 7'd1;
                                end
                                n_zf = 1'b0;
                            end else begin
                                if (r_dot == 9'd64) begin
                                    sl = '0;
                                    s  = {1'b0, r_start};
                                end
                                if (s[8]) begin
                                    s      = {1'b0, s[7:0]};
                                    n_copy = 1'b0;
                                end
                                if (!r_dot[0]) begin
                                    // Even dot: fetch primary byte
                                    o_pri_req.raddr = s[7:0];
                                    n_pend = ses_pkg::LAT_PRI;
                                end else if (n_copy) begin
                                    if (sl < 7'(ses_pkg::SPRITES_PER_LINE)) begin
                                        // Copy phase
                                        if (r_bis == 3'd0) begin
                                            o_sec_req.we    = 1'b1;
                                            o_sec_req.waddr = {3'd0, sl[2:0], 2'b00};
                                            o_sec_req.wdata = cur_lat;
                                        end
                                        if (hit && r_bis == 3'd0) begin
                                            if (r_dot == 9'd65) begin
                                                n_zf = 1'b1;
                                            end
                                            n_bis = r_bis + 3'd1;
                                            s     = s + 9'd1;
                                        end else if (r_bis != 3'd0 && r_bis < 3'd4) begin
                                            o_sec_req.we    = 1'b1;
                                            o_sec_req.waddr = {3'd0, sl[2:0], r_bis[1:0]};
                                            o_sec_req.wdata = cur_lat;
                                            s     = s + 9'd1;
                                            n_bis = r_bis + 3'd1;
                                            if (n_bis == 3'd4) begin
                                                if (!hit) begin
                                                    s = s & 9'h1FC;
                                                end
                                                sl    = sl + 7'd1;
                                                n_bis = '0;
                                            end
                                        end else begin
                                            s = (s + 9'd4) & 9'h1FC;
                                        end
                                    end else begin
                                        // Overflow search with misaligned step
                                        if (hit) begin
                                            n_ovf = 1'b1;
                                        end
                                        if (hit && r_bis == 3'd0) begin
                                            n_bis = r_bis + 3'd1;
                                            s     = s + 9'd1;
                                        end else if (r_bis != 3'd0 && r_bis < 3'd4) begin
                                            s     = s + 9'd1;
                                            n_bis = r_bis + 3'd1;
                                            if (n_bis == 3'd4) begin
                                                if (!hit) begin
                                                    s = s & 9'h1FC;
                                                end
                                                sl    = sl + 7'd1;
                                                n_bis = '0;
                                            end
                                        end else if (sl == 7'(ses_pkg::SPRITES_PER_LINE)) begin
                                            s = s + 9'd1;
                                            if (s[1:0] != 2'b00) begin
                                                s = s + 9'd4;
                                            end
                                        end else begin
                                            s = (s + 9'd4) & 9'h1FC;
                                        end
                                        o_sec_req.raddr = '0;
                                        n_pend = ses_pkg::LAT_SEC;
                                    end
                                end else begin
                                    // Copy disabled: read back secondary
                                    idx = {1'b0, sl, 2'b00} + {7'd0, r_bis};
                                    o_sec_req.raddr = (idx < 10'(ses_pkg::SECONDARY_BYTES))
                                                      ? {3'd0, idx[4:0]} : 8'd0;
                                    n_pend = ses_pkg::LAT_SEC;
                                    s = (s + 9'd4) & 9'h1FC;
                                end
                                n_slot = sl;
                                n_scan = s;
                            end
                        end
                    end
                end
                ses_pkg::OP_SEC_READ: begin
                    o_sec_req.raddr = {3'd0, i_table_address[4:0]};
                end
                default: begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_scan     <= '0;
            r_bis      <= '0;
            r_latched  <= '0;
            r_dot      <= '0;
            r_copy     <= 1'b1;
            r_zf       <= 1'b0;
            r_zl       <= 1'b0;
            r_ovf      <= 1'b0;
            r_line     <= '0;
            r_start    <= '0;
            r_pend     <= ses_pkg::LAT_REG;
            r_sec_vld  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_slot     <= n_slot;
            r_scan     <= n_scan;
            r_bis      <= n_bis;
            r_latched  <= cur_lat;
            r_dot      <= n_dot;
            r_copy     <= n_copy;
            r_zf       <= n_zf;
            r_zl       <= n_zl;
            r_ovf      <= n_ovf;
            r_line     <= n_line;
            r_start    <= n_start;
            r_pend     <= n_pend;
            r_s1_valid <= i_fire;
            if (o_sec_req.we) begin
                r_sec_vld[o_sec_req.waddr[ses_pkg::SEC_AW-1:0]] <= 1'b1;
            end
        end
    end

    // Result stage payload and read-side valid bit
    always_ff @(posedge i_clk) begin
        r_sec_vld_rd <= r_sec_vld[o_sec_req.raddr[ses_pkg::SEC_AW-1:0]];
        if (i_fire) begin
            r_s1_sec  <= (i_op == ses_pkg::OP_SEC_READ);
            r_s1_ovf  <= n_ovf;
            r_s1_zf   <= n_zf;
            r_s1_zl   <= n_zl;
            r_s1_slot <= n_slot;
        end
    end

    assign o_s1_valid             = r_s1_valid;
    assign o_push                 = r_s1_valid;
    assign o_result.bus_value     = r_s1_sec ? sec_data : cur_lat;
    assign o_result.overflow      = r_s1_ovf;
    assign o_result.zero_in_range = r_s1_zf;
    assign o_result.zero_for_line = r_s1_zl;
    assign o_result.sprites_found = r_s1_slot;

endmodule
